### hdl/calu_pkg.sv
// Package for the ALU execute unit: operation codes, register state type and
// payload types. Used by the channel interfaces, calu_execute and the top level.
// No dependencies.
package calu_pkg;

   localparam logic [5:0] OP_ADC = 6'd0;
   localparam logic [5:0] OP_SBC = 6'd1;
   localparam logic [5:0] OP_AND = 6'd2;
   localparam logic [5:0] OP_ORA = 6'd3;
   localparam logic [5:0] OP_EOR = 6'd4;
   localparam logic [5:0] OP_ASL = 6'd5;
   localparam logic [5:0] OP_LSR = 6'd6;
   localparam logic [5:0] OP_ROL = 6'd7;
   localparam logic [5:0] OP_ROR = 6'd8;
   localparam logic [5:0] OP_INC = 6'd9;
   localparam logic [5:0] OP_DEC = 6'd10;
   localparam logic [5:0] OP_INX = 6'd11;
   localparam logic [5:0] OP_INY = 6'd12;
   localparam logic [5:0] OP_DEX = 6'd13;
   localparam logic [5:0] OP_DEY = 6'd14;
   localparam logic [5:0] OP_CMP = 6'd15;
   localparam logic [5:0] OP_CPX = 6'd16;
   localparam logic [5:0] OP_CPY = 6'd17;
   localparam logic [5:0] OP_BIT = 6'd18;
   localparam logic [5:0] OP_LDA = 6'd19;
   localparam logic [5:0] OP_LDX = 6'd20;
   localparam logic [5:0] OP_LDY = 6'd21;
   localparam logic [5:0] OP_PLA = 6'd22;
   localparam logic [5:0] OP_STA = 6'd23;
   localparam logic [5:0] OP_STX = 6'd24;
   localparam logic [5:0] OP_STY = 6'd25;
   localparam logic [5:0] OP_TAX = 6'd26;
   localparam logic [5:0] OP_TAY = 6'd27;
   localparam logic [5:0] OP_TSX = 6'd28;
   localparam logic [5:0] OP_TXA = 6'd29;
   localparam logic [5:0] OP_TXS = 6'd30;
   localparam logic [5:0] OP_TYA = 6'd31;
   localparam logic [5:0] OP_CLC = 6'd32;
   localparam logic [5:0] OP_CLD = 6'd33;
   localparam logic [5:0] OP_CLI = 6'd34;
   localparam logic [5:0] OP_CLV = 6'd35;
   localparam logic [5:0] OP_SEC = 6'd36;
   localparam logic [5:0] OP_SED = 6'd37;
   localparam logic [5:0] OP_SEI = 6'd38;
   localparam logic [5:0] OP_BCC = 6'd39;
   localparam logic [5:0] OP_BCS = 6'd40;
   localparam logic [5:0] OP_BEQ = 6'd41;
   localparam logic [5:0] OP_BMI = 6'd42;
   localparam logic [5:0] OP_BNE = 6'd43;
   localparam logic [5:0] OP_BPL = 6'd44;
   localparam logic [5:0] OP_BVC = 6'd45;
   localparam logic [5:0] OP_BVS = 6'd46;

   localparam logic [7:0] SP_RESET = 8'hFD;

   typedef struct packed {
      logic n;
      logic v;
      logic d;
      logic i;
      logic z;
      logic c;
   } flags_type;

   typedef struct packed {
      logic [7:0] accumulator;
      logic [7:0] index_x;
      logic [7:0] index_y;
      logic [7:0] stack_pointer;
      flags_type  flags;
   } state_type;

   typedef struct packed {
      logic [5:0] operation;
      logic [7:0] operand;
      logic       to_accumulator;
   } req_type;

   typedef struct packed {
      logic [7:0] write_byte;
      logic       write_memory;
      logic       branch_taken;
      logic       page_cycle_eligible;
      logic [7:0] accumulator_out;
      logic [7:0] index_x_out;
      logic [7:0] index_y_out;
      logic [7:0] stack_pointer_out;
      logic [7:0] status_out;
   } rsp_type;

   localparam state_type STATE_RESET = '{
      accumulator:   8'h00,
      index_x:       8'h00,
      index_y:       8'h00,
      stack_pointer: SP_RESET,
      flags:         '{n: 1'b0, v: 1'b0, d: 1'b0, i: 1'b1, z: 1'b0, c: 1'b0}
   };

   // Pack flags as N V 1 0 D I Z C.
   function automatic logic [7:0] status_pack(flags_type f);
      return {f.n, f.v, 1'b1, 1'b0, f.d, f.i, f.z, f.c};
   endfunction

endpackage

### hdl/calu_channels.sv
// Valid/ready channel interfaces for the ALU execute unit request and response.
// Depends on calu_pkg.
interface calu_req_if
   import calu_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [5:0] operation;
   logic [7:0] operand;
   logic       to_accumulator;

   modport source (output valid, output operation, output operand, output to_accumulator,
                   input ready);
   modport sink   (input valid, input operation, input operand, input to_accumulator,
                   output ready);
endinterface

interface calu_rsp_if
   import calu_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic [7:0] write_byte;
   logic       write_memory;
   logic       branch_taken;
   logic       page_cycle_eligible;
   logic [7:0] accumulator_out;
   logic [7:0] index_x_out;
   logic [7:0] index_y_out;
   logic [7:0] stack_pointer_out;
   logic [7:0] status_out;

   modport source (output valid, output write_byte, output write_memory,
                   output branch_taken, output page_cycle_eligible,
                   output accumulator_out, output index_x_out, output index_y_out,
                   output stack_pointer_out, output status_out, input ready);
   modport sink   (input valid, input write_byte, input write_memory,
                   input branch_taken, input page_cycle_eligible,
                   input accumulator_out, input index_x_out, input index_y_out,
                   input stack_pointer_out, input status_out, output ready);
endinterface

### hdl/cpu_alu_execute_unit_core.sv
// Top level of the ALU execute unit: request register, execute logic, state
// registers and response register. Depends on calu_pkg, calu_channels, calu_execute.
//
//   channel    dir  handshake      word
//   req_chan   in   valid/ready    operation, operand, to_accumulator
//   rsp_chan   out  valid/ready    write_byte .. status_out (9 fields)
//
// One word per cycle while the response is not stalled; an accepted word passes
// through the request register and then the response register on its way out.
// The register file and flags update in the cycle the word moves into the
// response register, so the next word sees the new state directly.
// Synchronous active-high reset clears both stages and loads A/X/Y=0, SP=FD, I=1.
// A stalled response holds; the request register takes words while it is empty,
// or while the response register is free or is being drained in the same cycle.
module cpu_alu_execute_unit_core
   import calu_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   calu_req_if.sink          req_chan,
   calu_rsp_if.source        rsp_chan
);

   logic      s1_valid_ff;
   logic      s1_valid_in;
   req_type   s1_item_ff;
   logic      out_valid_ff;
   logic      out_valid_in;
   rsp_type   out_rsp_ff;
   state_type state_ff;
   state_type state_next;
   rsp_type   exec_rsp;
   logic      accept;
   logic      advance;

   assign advance = s1_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign accept  = req_chan.valid & req_chan.ready;
   assign req_chan.ready = ~s1_valid_ff | advance;

   assign s1_valid_in  = accept | (s1_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_chan.ready);

   calu_execute u_execute (
      .item       (s1_item_ff),
      .state      (state_ff),
      .state_next (state_next),
      .rsp        (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload registers: load only on a move.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{operation:      req_chan.operation,
                         operand:        req_chan.operand,
                         to_accumulator: req_chan.to_accumulator};
      end
      if (advance) begin
         out_rsp_ff <= exec_rsp;
      end
   end

   assign rsp_chan.valid               = out_valid_ff;
   assign rsp_chan.write_byte          = out_rsp_ff.write_byte;
   assign rsp_chan.write_memory        = out_rsp_ff.write_memory;
   assign rsp_chan.branch_taken        = out_rsp_ff.branch_taken;
   assign rsp_chan.page_cycle_eligible = out_rsp_ff.page_cycle_eligible;
   assign rsp_chan.accumulator_out     = out_rsp_ff.accumulator_out;
   assign rsp_chan.index_x_out         = out_rsp_ff.index_x_out;
   assign rsp_chan.index_y_out         = out_rsp_ff.index_y_out;
   assign rsp_chan.stack_pointer_out   = out_rsp_ff.stack_pointer_out;
   assign rsp_chan.status_out          = out_rsp_ff.status_out;

   // Architectural state moves only when a word goes to the response register.
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("state changed without a word advancing");

   // Response register status and accumulator match the live state after a move.
   assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_valid_ff && rsp_chan.status_out == status_pack(state_ff.flags)
                   && rsp_chan.accumulator_out == state_ff.accumulator))
      else $error("response does not match updated state");

   // No store byte without a store.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.write_memory |-> rsp_chan.write_byte == 8'h00)
      else $error("write byte set without write enable");

   // Branches neither store nor take the page cycle.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_chan.branch_taken |->
         !rsp_chan.write_memory && !rsp_chan.page_cycle_eligible)
      else $error("branch word carries store or page flag");

endmodule

### hdl/calu_execute.sv
// Combinational execute logic: applies one operation to the register state
// and builds the response word and the next state. Depends on calu_pkg.
module calu_execute
   import calu_pkg::*;
(
   input  req_type   item,
   input  state_type state,
   output state_type state_next,
   output rsp_type   rsp
);

   logic [7:0] m;
   logic [7:0] addend;
   logic [8:0] sum;
   logic       add_v;
   logic [7:0] cmp_reg;
   logic [8:0] diff;
   logic [7:0] shift_res;
   logic       shift_c;
   logic [7:0] wbyte;
   logic       wmem;
   logic       taken;
   logic       page;
   logic [7:0] nz_val;
   logic       nz_en;
   state_type  ns;

   assign m = item.operand;

   // Shared adder for ADC and SBC; SBC adds the inverted operand.
   assign addend = (item.operation == OP_SBC) ? ~m : m;
   assign sum    = {1'b0, state.accumulator} + {1'b0, addend} + {8'b0, state.flags.c};
   assign add_v  = ~(state.accumulator[7] ^ addend[7]) & (state.accumulator[7] ^ sum[7]);

   always_comb begin
      case (item.operation)
         OP_CPX:  cmp_reg = state.index_x;
         OP_CPY:  cmp_reg = state.index_y;
         default: cmp_reg = state.accumulator;
      endcase
   end

   assign diff = {1'b0, cmp_reg} - {1'b0, m};

   always_comb begin
      case (item.operation)
         OP_ASL: begin
            shift_res = {m[6:0], 1'b0};
            shift_c   = m[7];
         end
         OP_LSR: begin
            shift_res = {1'b0, m[7:1]};
            shift_c   = m[0];
         end
         OP_ROL: begin
            shift_res = {m[6:0], state.flags.c};
            shift_c   = m[7];
         end
         OP_ROR: begin
            shift_res = {state.flags.c, m[7:1]};
            shift_c   = m[0];
         end
         default: begin
            shift_res = m;
            shift_c   = state.flags.c;
         end
      endcase
   end

   assign page     = item.operation inside {OP_ADC, OP_SBC, OP_AND, OP_ORA, OP_EOR,
                                            OP_CMP, OP_CPX, OP_CPY, OP_LDA, OP_LDX, OP_LDY};

   always_comb begin
      ns     = state;
      wbyte  = 8'h00;
      wmem   = 1'b0;
      taken  = 1'b0;
      nz_val = 8'h00;
      nz_en  = 1'b0;
      case (item.operation)
         OP_ADC, OP_SBC: begin
            ns.accumulator = sum[7:0];
            ns.flags.c     = sum[8];
            ns.flags.v     = add_v;
            nz_val = sum[7:0];
            nz_en  = 1'b1;
         end
         OP_AND: begin
            ns.accumulator = state.accumulator & m;
            nz_val = ns.accumulator;
            nz_en  = 1'b1;
         end
         OP_ORA: begin
            ns.accumulator = state.accumulator | m;
            nz_val = ns.accumulator;
            nz_en  = 1'b1;
         end
         OP_EOR: begin
            ns.accumulator = state.accumulator ^ m;
            nz_val = ns.accumulator;
            nz_en  = 1'b1;
         end
         OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
            ns.flags.c = shift_c;
            nz_val = shift_res;
            nz_en  = 1'b1;
            if (item.to_accumulator) begin
               ns.accumulator = shift_res;
            end else begin
               wbyte = shift_res;
               wmem  = 1'b1;
            end
         end
         OP_INC: begin
            wbyte  = m + 8'd1;
            wmem   = 1'b1;
            nz_val = wbyte;
            nz_en  = 1'b1;
         end
         OP_DEC: begin
            wbyte  = m - 8'd1;
            wmem   = 1'b1;
            nz_val = wbyte;
            nz_en  = 1'b1;
         end
         OP_INX: begin
            ns.index_x = state.index_x + 8'd1;
            nz_val = ns.index_x;
            nz_en  = 1'b1;
         end
         OP_INY: begin
            ns.index_y = state.index_y + 8'd1;
            nz_val = ns.index_y;
            nz_en  = 1'b1;
         end
         OP_DEX: begin
            ns.index_x = state.index_x - 8'd1;
            nz_val = ns.index_x;
            nz_en  = 1'b1;
         end
         OP_DEY: begin
            ns.index_y = state.index_y - 8'd1;
            nz_val = ns.index_y;
            nz_en  = 1'b1;
         end
         OP_CMP, OP_CPX, OP_CPY: begin
            ns.flags.c = ~diff[8];
            nz_val = diff[7:0];
            nz_en  = 1'b1;
         end
         OP_BIT: begin
            ns.flags.z = ((state.accumulator & m) == 8'h00);
            ns.flags.n = m[7];
            ns.flags.v = m[6];
         end
         OP_LDA: begin
            ns.accumulator = m;
            nz_val = m;
            nz_en  = 1'b1;
         end
         OP_LDX: begin
            ns.index_x = m;
            nz_val = m;
            nz_en  = 1'b1;
         end
         OP_LDY: begin
            ns.index_y = m;
            nz_val = m;
            nz_en  = 1'b1;
         end
         OP_PLA: begin
            ns.accumulator   = m;
            ns.stack_pointer = state.stack_pointer + 8'd1;
            nz_val = m;
            nz_en  = 1'b1;
         end
         OP_STA: begin
            wbyte = state.accumulator;
            wmem  = 1'b1;
         end
         OP_STX: begin
            wbyte = state.index_x;
            wmem  = 1'b1;
         end
         OP_STY: begin
            wbyte = state.index_y;
            wmem  = 1'b1;
         end
         OP_TAX: begin
            ns.index_x = state.accumulator;
            nz_val = state.accumulator;
            nz_en  = 1'b1;
         end
         OP_TAY: begin
            ns.index_y = state.accumulator;
            nz_val = state.accumulator;
            nz_en  = 1'b1;
         end
         OP_TSX: begin
            ns.index_x = state.stack_pointer;
            nz_val = state.stack_pointer;
            nz_en  = 1'b1;
         end
         OP_TXA: begin
            ns.accumulator = state.index_x;
            nz_val = state.index_x;
            nz_en  = 1'b1;
         end
         OP_TXS:  ns.stack_pointer = state.index_x;
         OP_TYA: begin
            ns.accumulator = state.index_y;
            nz_val = state.index_y;
            nz_en  = 1'b1;
         end
         OP_CLC:  ns.flags.c = 1'b0;
         OP_CLD:  ns.flags.d = 1'b0;
         OP_CLI:  ns.flags.i = 1'b0;
         OP_CLV:  ns.flags.v = 1'b0;
         OP_SEC:  ns.flags.c = 1'b1;
         OP_SED:  ns.flags.d = 1'b1;
         OP_SEI:  ns.flags.i = 1'b1;
         OP_BCC:  taken = ~state.flags.c;
         OP_BCS:  taken = state.flags.c;
         OP_BEQ:  taken = state.flags.z;
         OP_BMI:  taken = state.flags.n;
         OP_BNE:  taken = ~state.flags.z;
         OP_BPL:  taken = ~state.flags.n;
         OP_BVC:  taken = ~state.flags.v;
         OP_BVS:  taken = state.flags.v;
         default: ns = state;
      endcase
      if (nz_en) begin
         ns.flags.n = nz_val[7];
         ns.flags.z = (nz_val == 8'h00);
      end
   end

   assign state_next = ns;

   always_comb begin
      rsp.write_byte          = wbyte;
      rsp.write_memory        = wmem;
      rsp.branch_taken        = taken;
      rsp.page_cycle_eligible = page;
      rsp.accumulator_out     = ns.accumulator;
      rsp.index_x_out         = ns.index_x;
      rsp.index_y_out         = ns.index_y;
      rsp.stack_pointer_out   = ns.stack_pointer;
      rsp.status_out          = status_pack(ns.flags);
   end

endmodule
